// ===== hdl/windowed_true_rms_meter_assert.svh =====
// Assertion shorthands used by the top-level RTL file.
`ifndef WINDOWED_TRUE_RMS_METER_ASSERT_SVH
`define WINDOWED_TRUE_RMS_METER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WRMS_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define WRMS_HOLDS_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wrms_pkg.sv =====
package wrms_pkg;

  localparam int SAMPLE_BITS     = 12;
  localparam int MAX_SAMPLES_DEF = 1024;

  localparam int COUNT_W  = 11;
  localparam int FSCALE_W = 13;
  localparam int OFFSET_W = 10;
  localparam int MV_W     = 13;

  localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(300);
  localparam logic [FSCALE_W-1:0] FSCALE_RESET = FSCALE_W'(3300);
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(110);
  localparam logic [MV_W-1:0]     MV_MAX       = '1;

  // squaring and scaling both walk their multiplier four bits at a time
  localparam int SQ_DIGIT = 4;
  localparam int SQ_STEPS = (SAMPLE_BITS + SQ_DIGIT - 1) / SQ_DIGIT;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_SAMPLE_COUNT = 2'd0,
    REG_FULL_SCALE   = 2'd1,
    REG_OFFSET       = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIVIDE,
    ST_ROOT,
    ST_SCALE,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/wrms_div.sv =====
module wrms_div #(
  parameter int DVD_W = 34,
  parameter int DVS_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // restoring division, one quotient bit per cycle, quotient shifts into dvd
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], fits};
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign quotient = dvd;

endmodule

// ===== hdl/wrms_isqrt.sv =====
module wrms_isqrt #(
  parameter int ROOT_W = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2*ROOT_W-1:0] radicand,
  output logic                done,
  output logic [ROOT_W-1:0]   root
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W+1:0]   rem;
  logic [ROOT_W+3:0]   cur;
  logic [ROOT_W+3:0]   trial;
  logic [ROOT_W+3:0]   diff;
  logic                fits;

  // digit-by-digit root: bring down two radicand bits, try root*4+1
  always_comb begin
    cur   = {rem, rad[2*ROOT_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    diff  = cur - trial;
    fits  = cur >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? diff[ROOT_W+1:0] : cur[ROOT_W+1:0];
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

// ===== hdl/windowed_true_rms_meter.sv =====
// True-RMS meter over a window of sample_count converter samples (0 acts as 1,
// values above MAX_SAMPLES act as MAX_SAMPLES). Each sample's exact square is
// added to a wide accumulator four sample bits per cycle, and in_ready stays
// low until that square is in. The sample that closes the window also runs a
// bit-serial divide by the window length (one quotient bit per accumulator
// bit), a bit-serial square root (one step per root bit), a digit-serial
// scale to millivolts and the load of the output register; no new sample is
// taken until that load, which waits while the previous word is still held.
// One word with rms_code and rms_mv is emitted per window; it waits in an
// output register while the next window accumulates. A window shortened
// below the samples already taken can push the mean past the code range, so
// the root is kept at 17 bits: rms_code is its low 12 bits and rms_mv
// saturates at 8191.
`include "windowed_true_rms_meter_assert.svh"

module windowed_true_rms_meter
  import wrms_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] rms_code,
  output logic [MV_W-1:0]        rms_mv,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W    = 2 * SAMPLE_BITS + $clog2(MAX_SAMPLES);
  localparam int MEAN_W   = 2 * SAMPLE_BITS;
  localparam int ROOT_W   = (SUM_W + 1) / 2;
  localparam int SC_STEPS = (ROOT_W + SQ_DIGIT - 1) / SQ_DIGIT;
  localparam int RSR_W    = SC_STEPS * SQ_DIGIT;
  localparam int STEP_W   = $clog2(SC_STEPS);
  localparam int PROD_W   = ROOT_W + FSCALE_W;
  localparam int MVW_W    = PROD_W - SAMPLE_BITS + 1;

  state_t state, state_next;

  logic [COUNT_W-1:0]  sample_count;
  logic [FSCALE_W-1:0] full_scale_mv;
  logic [OFFSET_W-1:0] offset_mv;

  logic [SUM_W-1:0]         square_sum;
  logic [SUM_W-1:0]         sum_next;
  logic [CNT_W-1:0]         samples_seen;
  logic [CNT_W-1:0]         n_eff;
  logic                     window_full;
  logic [MEAN_W-1:0]        mcand;
  logic [SAMPLE_BITS-1:0]   mplier;
  logic [STEP_W-1:0]        step;
  logic                     last_step;
  logic [SAMPLE_BITS-1:0]   root_val;
  logic [RSR_W-1:0]         root_sr;
  logic [PROD_W-1:0]        prod;
  logic [MVW_W-1:0]         mv_wide;
  logic [MV_W-1:0]          mv_sat;

  logic                     div_start;
  logic                     div_done;
  logic [SUM_W-1:0]         quotient;
  logic                     sqrt_start;
  logic                     sqrt_done;
  logic [ROOT_W-1:0]        sqrt_root;
  logic                     emit;
  logic                     cfg_write;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= COUNT_RESET;
      full_scale_mv <= FSCALE_RESET;
      offset_mv     <= OFFSET_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_SAMPLE_COUNT: sample_count  <= pwdata[COUNT_W-1:0];
        REG_FULL_SCALE:   full_scale_mv <= pwdata[FSCALE_W-1:0];
        REG_OFFSET:       offset_mv     <= pwdata[OFFSET_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SAMPLE_COUNT: prdata = APB_DW'(sample_count);
      REG_FULL_SCALE:   prdata = APB_DW'(full_scale_mv);
      REG_OFFSET:       prdata = APB_DW'(offset_mv);
      default:          prdata = '0;
    endcase
  end

  // window length clamp, end-of-window test, step end, next sum and mV saturation
  always_comb begin
    if (sample_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(sample_count) > MAX_SAMPLES) begin
      n_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      n_eff = CNT_W'(sample_count);
    end
    window_full = samples_seen >= n_eff;
    if (state == ST_SCALE) begin
      last_step = step == STEP_W'(SC_STEPS - 1);
    end else begin
      last_step = step == STEP_W'(SQ_STEPS - 1);
    end
    sum_next    = square_sum + SUM_W'(mcand) * SUM_W'(mplier[SQ_DIGIT-1:0]);
    mv_wide     = MVW_W'(prod >> SAMPLE_BITS) + MVW_W'(offset_mv);
    mv_sat      = (mv_wide > MVW_W'(MV_MAX)) ? MV_MAX : mv_wide[MV_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && in_ready) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (last_step) begin
          if (window_full) begin
            div_start  = 1'b1;
            state_next = ST_DIVIDE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (last_step) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      samples_seen <= '0;
      step         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == ST_SQUARE || state == ST_SCALE) begin
        step <= last_step ? '0 : step + 1'b1;
      end else begin
        step <= '0;
      end

      if (in_valid && in_ready) begin
        samples_seen <= samples_seen + 1'b1;
      end
      if (state == ST_SQUARE) begin
        square_sum <= sum_next;
      end

      if (emit) begin
        out_valid    <= 1'b1;
        square_sum   <= '0;
        samples_seen <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mcand  <= MEAN_W'(sample);
      mplier <= sample;
    end else if (state == ST_SQUARE) begin
      mcand  <= mcand << SQ_DIGIT;
      mplier <= mplier >> SQ_DIGIT;
    end

    if (sqrt_done) begin
      root_val <= sqrt_root[SAMPLE_BITS-1:0];
      root_sr  <= RSR_W'(sqrt_root);
      prod     <= '0;
    end else if (state == ST_SCALE) begin
      // Horner form, most significant digit of the root first
      prod    <= PROD_W'(prod << SQ_DIGIT)
               + PROD_W'(full_scale_mv) * PROD_W'(root_sr[RSR_W-1 -: SQ_DIGIT]);
      root_sr <= root_sr << SQ_DIGIT;
    end

    if (emit) begin
      rms_code <= root_val;
      rms_mv   <= mv_sat;
    end
  end

  wrms_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum_next),
    .divisor (n_eff),
    .done    (div_done),
    .quotient(quotient)
  );

  wrms_isqrt #(
    .ROOT_W(ROOT_W)
  ) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .radicand((2 * ROOT_W)'(quotient)),
    .done    (sqrt_done),
    .root    (sqrt_root)
  );

  `WRMS_HOLDS(a_seen_bounded, clk, rst, 1'b1, 32'(samples_seen) <= MAX_SAMPLES, "window count past limit")
  `WRMS_HOLDS(a_div_in_divide, clk, rst, div_done, state == ST_DIVIDE, "divider finished outside divide")
  `WRMS_HOLDS_NEXT(a_emit_clears, clk, rst, emit, out_valid && square_sum == '0 && samples_seen == '0, "window not cleared after emit")
  `WRMS_HOLDS_NEXT(a_accept_squares, clk, rst, in_valid && in_ready, state == ST_SQUARE && step == '0, "accepted word not squared")

endmodule

// ===== sim/tb.sv =====
module tb
  import wrms_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT      = 500000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int IDLE_PCT       = 28;
  localparam int MISMATCH_SHOWN = 10;
  localparam int WINDOW_MAX     = MAX_SAMPLES_DEF;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
  localparam int ROOT_BITS      = 17;
  // first address past the register map
  localparam logic [APB_AW-1:0] ADDR_BEYOND_LAST = APB_AW'(12);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] code;
    logic [MV_W-1:0]        mv;
  } rms_word_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] sample    = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] rms_code;
  logic [MV_W-1:0]        rms_mv;
  logic                   psel      = 1'b0;
  logic                   penable   = 1'b0;
  logic                   pwrite    = 1'b0;
  logic [APB_AW-1:0]      paddr     = '0;
  logic [APB_DW-1:0]      pwdata    = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  // predictor state and its copy of the registers
  logic [33:0]         sum_sq         = '0;
  logic [COUNT_W-1:0]  seen_in_window = '0;
  logic [COUNT_W-1:0]  cfg_count      = COUNT_RESET;
  logic [FSCALE_W-1:0] cfg_fscale     = FSCALE_RESET;
  logic [OFFSET_W-1:0] cfg_offset     = OFFSET_RESET;
  rms_word_t           rms_expected[$];

  int mismatches    = 0;
  int cycle_count   = 0;
  bit steady        = 1'b0;
  int hold_req      = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  windowed_true_rms_meter u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sample   (sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rms_code (rms_code),
    .rms_mv   (rms_mv),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [ROOT_BITS-1:0] isqrt_floor(input logic [33:0] v);
    logic [ROOT_BITS-1:0] root;
    logic [ROOT_BITS-1:0] trial;
    root = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      trial = root | (ROOT_BITS'(1) << b);
      if (34'(trial) * 34'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= MISMATCH_SHOWN)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  // accumulate one square; close the window when it is full
  task automatic accumulate_sample(input logic [SAMPLE_BITS-1:0] s);
    logic [COUNT_W-1:0]   win;
    logic [33:0]          mean;
    logic [ROOT_BITS-1:0] root;
    logic [31:0]          mv;
    rms_word_t            word;
    win = (cfg_count == 0) ? COUNT_W'(1) :
          (cfg_count > WINDOW_MAX) ? COUNT_W'(WINDOW_MAX) : cfg_count;
    sum_sq = sum_sq + 34'(s) * 34'(s);
    seen_in_window = seen_in_window + 1'b1;
    if (seen_in_window >= win) begin
      mean = sum_sq / 34'(win);
      root = isqrt_floor(mean);
      word.code = root[SAMPLE_BITS-1:0];
      mv = ((32'(root) * 32'(cfg_fscale)) >> SAMPLE_BITS) + 32'(cfg_offset);
      if (mv > 32'(MV_MAX)) mv = 32'(MV_MAX);
      word.mv = mv[MV_W-1:0];
      rms_expected.push_back(word);
      sum_sq = '0;
      seen_in_window = '0;
    end
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accumulate_sample(s);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return SAMPLE_BITS'(SAMPLE_MAX);
      2:       return SAMPLE_BITS'($urandom_range(15));
      default: return SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
    endcase
  endfunction

  // drop valid, drain all results, then let the block finish any square
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (rms_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input reg_index_t idx, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] rdata;
    apb_access(1'b0, APB_AW'({idx, 2'b00}), '0, rdata);
    if (rdata !== want) note_mismatch($sformatf("register %s", idx.name()), want, rdata);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] rdata;
    apb_access(1'b1, APB_AW'({idx, 2'b00}), value, rdata);
    case (idx)
      REG_SAMPLE_COUNT: cfg_count  = value[COUNT_W-1:0];
      REG_FULL_SCALE:   cfg_fscale = value[FSCALE_W-1:0];
      REG_OFFSET:       cfg_offset = value[OFFSET_W-1:0];
      default: ;
    endcase
    check_reg(REG_SAMPLE_COUNT, APB_DW'(cfg_count));
    check_reg(REG_FULL_SCALE, APB_DW'(cfg_fscale));
    check_reg(REG_OFFSET, APB_DW'(cfg_offset));
  endtask

  // receiver: random stalls, or a long hold when a test asks for one
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_req) begin
      hold_served <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    rms_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (rms_expected.size() == 0) begin
        note_mismatch("unexpected word, rms_code", -1, rms_code);
      end else begin
        want = rms_expected.pop_front();
        if (rms_code !== want.code) note_mismatch("rms_code", want.code, rms_code);
        if (rms_mv !== want.mv) note_mismatch("rms_mv", want.mv, rms_mv);
      end
    end
  end

  task automatic test_reset_values();
    check_reg(REG_SAMPLE_COUNT, APB_DW'(COUNT_RESET));
    check_reg(REG_FULL_SCALE, APB_DW'(FSCALE_RESET));
    check_reg(REG_OFFSET, APB_DW'(OFFSET_RESET));
  endtask

  task automatic test_single_sample_windows();
    write_reg(REG_SAMPLE_COUNT, 1);
    write_reg(REG_FULL_SCALE, 1000);
    write_reg(REG_OFFSET, 0);
    send_sample('0);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'h001);
    wait_idle();
  endtask

  // a zero window length behaves as one
  task automatic test_zero_window();
    write_reg(REG_SAMPLE_COUNT, 0);
    write_reg(REG_FULL_SCALE, 5000);
    write_reg(REG_OFFSET, 1000);
    send_sample(12'h800);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    wait_idle();
  endtask

  task automatic test_mv_saturation();
    write_reg(REG_SAMPLE_COUNT, 1);
    write_reg(REG_FULL_SCALE, 32'h1FFF);
    write_reg(REG_OFFSET, 32'h3FF);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    send_sample(12'hC00);
    wait_idle();
  endtask

  task automatic test_masked_writes();
    logic [APB_DW-1:0] rdata;
    write_reg(REG_SAMPLE_COUNT, 32'hFFFF_F802);
    write_reg(REG_FULL_SCALE, 32'hFFFF_E3E8);
    write_reg(REG_OFFSET, 32'hFFFF_FC05);
    // past the last register: nothing may change
    apb_access(1'b1, ADDR_BEYOND_LAST, 32'h0000_0001, rdata);
    check_reg(REG_SAMPLE_COUNT, APB_DW'(cfg_count));
    check_reg(REG_FULL_SCALE, APB_DW'(cfg_fscale));
    check_reg(REG_OFFSET, APB_DW'(cfg_offset));
    send_sample(12'h800);
    send_sample(12'h7FF);
    wait_idle();
  endtask

  // shrink the window below the samples already taken
  task automatic test_window_shrink();
    write_reg(REG_SAMPLE_COUNT, 8);
    write_reg(REG_FULL_SCALE, 3300);
    write_reg(REG_OFFSET, 110);
    repeat (5) send_sample(pick_sample());
    wait_idle();
    write_reg(REG_SAMPLE_COUNT, 1);
    send_sample(pick_sample());
    wait_idle();
  endtask

  // hold the receiver while samples keep coming so the input stalls
  task automatic test_backpressure();
    write_reg(REG_SAMPLE_COUNT, 1);
    steady = 1'b1;
    hold_req++;
    repeat (40) send_sample(pick_sample());
    steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_windows(input int item_goal);
    int sent;
    int phase;
    int burst;
    sent  = 0;
    phase = 0;
    while (sent < item_goal) begin
      wait_idle();
      steady = (phase == 4);
      case ($urandom_range(9))
        0:       write_reg(REG_SAMPLE_COUNT, 0);
        1:       write_reg(REG_SAMPLE_COUNT, $urandom_range(13, 48));
        2:       write_reg(REG_SAMPLE_COUNT, 1);
        default: write_reg(REG_SAMPLE_COUNT, $urandom_range(2, 12));
      endcase
      case ($urandom_range(5))
        0:       write_reg(REG_FULL_SCALE, 1000);
        1:       write_reg(REG_FULL_SCALE, 5000);
        2:       write_reg(REG_FULL_SCALE, 32'h1FFF);
        default: write_reg(REG_FULL_SCALE, $urandom_range(1000, 5000));
      endcase
      case ($urandom_range(5))
        0:       write_reg(REG_OFFSET, 0);
        1:       write_reg(REG_OFFSET, 1000);
        2:       write_reg(REG_OFFSET, 32'h3FF);
        default: write_reg(REG_OFFSET, $urandom_range(1000));
      endcase
      burst = $urandom_range(20, 60);
      repeat (burst) send_sample(pick_sample());
      sent += burst;
      phase++;
    end
    steady = 1'b0;
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_single_sample_windows();
    test_zero_window();
    test_mv_saturation();
    test_masked_writes();
    test_window_shrink();
    test_backpressure();
    test_random_windows(470);
    wait_idle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
